/* sv/bcu_pkg.sv */
// ----------------------------------------------------------------------------
// Binomial coefficient unit package
// Field widths and payload types shared by the channels and the datapath.
// ----------------------------------------------------------------------------
package bcu_pkg;

  localparam int DegW  = 8;   // degree and index fields, two's complement
  localparam int CoefW = 31;  // result coefficient, unsigned

  localparam logic [CoefW-1:0] CoefMax = {CoefW{1'b1}};

  typedef logic signed [DegW-1:0] arg_t;
  typedef logic [CoefW-1:0]       coef_t;

endpackage

/* sv/bcu_if.sv */
// ----------------------------------------------------------------------------
// Binomial coefficient unit channels
// Valid/ready channels for the argument pair and for the result.
// ----------------------------------------------------------------------------
interface bcu_in_if import bcu_pkg::*;;
  logic valid;
  logic ready;
  arg_t degree;
  arg_t coeff_index;

  modport source (output valid, output degree, output coeff_index, input ready);
  modport sink   (input valid, input degree, input coeff_index, output ready);
endinterface

interface bcu_out_if import bcu_pkg::*;;
  logic  valid;
  logic  ready;
  coef_t coefficient;
  logic  out_of_range;

  modport source (output valid, output coefficient, output out_of_range, input ready);
  modport sink   (input valid, input coefficient, input out_of_range, output ready);
endinterface

/* sv/binomial_coefficient_unit.sv */
// ----------------------------------------------------------------------------
// Binomial coefficient unit
// Returns C(n,k) for a signed degree n and index k by Pascal's rule.
// ----------------------------------------------------------------------------
// One item in, one result out. An accepted pair (n, k) with 0 <= k <= n <=
// MAX_DEGREE builds the triangle one row per cycle in a single row of lane
// adders (bcu_row_step) over n row updates, and the result is registered from
// StDone into the output register as soon as that register is free to take it.
// The first n-k steps are plain Pascal steps; the last k steps also shift the
// row down one lane, so C(n,k) ends up in lane 0 and no index mux is needed.
// A negative degree or index, or k > n, gives 0 at once; a degree above
// MAX_DEGREE gives 0 with out_of_range set. Values that do not fit 31 bits
// saturate to all ones (only possible for MAX_DEGREE above 33). The input is
// not ready while an item is in work; a finished result sits in the output
// register until its transfer, and the next item can be taken meanwhile.
// ----------------------------------------------------------------------------
module binomial_coefficient_unit import bcu_pkg::*; #(
  parameter int MAX_DEGREE = 33
) (
  input  logic clk_i,
  input  logic rst_ni,
  bcu_in_if.sink    in_i,
  bcu_out_if.source out_o
);

  // Row entries stay below 2**MAX_DEGREE, so MAX_DEGREE bits hold them.
  localparam int Lanes  = MAX_DEGREE + 1;
  localparam int EntryW = MAX_DEGREE;
  localparam int CntW   = $clog2(MAX_DEGREE + 1);
  localparam int WideW  = (EntryW > CoefW) ? EntryW : CoefW;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDone
  } state_e;

  state_e state_q;

  logic [EntryW-1:0] row_q [Lanes];
  logic [EntryW-1:0] row_d [Lanes];
  logic [CntW-1:0]   rem_q;    // row steps still to go
  logic [CntW-1:0]   idx_q;    // k; shifted steps are the last k
  logic              zero_q;   // result forced to zero
  logic              oor_q;    // degree above MAX_DEGREE
  logic              step_shift;

  logic              out_valid_q;
  coef_t             out_coef_q;
  logic              out_oor_q;

  logic              in_xfer;
  logic              out_free;
  logic              deg_over;
  logic              args_bad;
  logic [WideW-1:0]  lane0_wide;
  coef_t             coef_sat;

  assign in_i.ready = (state_q == StIdle);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign deg_over = (int'(in_i.degree) > MAX_DEGREE);
  assign args_bad = in_i.degree[DegW-1] || in_i.coeff_index[DegW-1] ||
                    (in_i.coeff_index > in_i.degree);

  assign step_shift = (rem_q <= idx_q);

  bcu_row_step #(
    .Lanes  (Lanes),
    .EntryW (EntryW)
  ) u_row_step (
    .row_i   (row_q),
    .shift_i (step_shift),
    .row_o   (row_d)
  );

  // saturate lane 0 into the 31-bit result
  assign lane0_wide = WideW'(row_q[0]);
  assign coef_sat   = (lane0_wide > WideW'(CoefMax)) ? CoefMax : lane0_wide[CoefW-1:0];

  // control and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rem_q       <= '0;
      idx_q       <= '0;
      zero_q      <= 1'b0;
      oor_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_coef_q  <= '0;
      out_oor_q   <= 1'b0;
    end else begin
      // in StDone a result transfer always frees the slot for the next one
      if (out_valid_q && out_o.ready && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_xfer) begin
            oor_q  <= deg_over;
            zero_q <= deg_over || args_bad;
            rem_q  <= in_i.degree[CntW-1:0];
            idx_q  <= in_i.coeff_index[CntW-1:0];
            if (deg_over || args_bad || (in_i.degree == '0)) begin
              state_q <= StDone;
            end else begin
              state_q <= StRun;
            end
          end
        end
        StRun: begin
          rem_q <= rem_q - CntW'(1);
          if (rem_q == CntW'(1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_coef_q  <= zero_q ? '0 : coef_sat;
            out_oor_q   <= oor_q;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // row storage: seeded with row 0 on a transfer, stepped while running
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int c = 0; c < Lanes; c++) begin
        row_q[c] <= (c == 0) ? EntryW'(1) : '0;
      end
    end else if (state_q == StRun) begin
      row_q <= row_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.coefficient  = out_coef_q;
  assign out_o.out_of_range = out_oor_q;

endmodule

/* sv/bcu_row_step.sv */
// ----------------------------------------------------------------------------
// Pascal row step
// One row of lane adders: next row of the triangle, optionally shifted down
// by one lane in the same step.
// ----------------------------------------------------------------------------
module bcu_row_step #(
  parameter int Lanes  = 34,
  parameter int EntryW = 33
) (
  input  logic [EntryW-1:0] row_i [Lanes],
  input  logic              shift_i,
  output logic [EntryW-1:0] row_o [Lanes]
);

  for (genvar c = 0; c < Lanes; c++) begin : g_lane
    logic [EntryW-1:0] lo, hi;

    // plain step: new[c] = old[c] + old[c-1]
    // shifted step: new[c] = old[c+1] + old[c] (lane c now holds index c+1)
    if (c == 0) begin : g_bot
      assign lo = shift_i ? row_i[c] : '0;
    end else begin : g_mid
      assign lo = shift_i ? row_i[c] : row_i[c-1];
    end

    if (c == Lanes - 1) begin : g_top
      assign hi = shift_i ? '0 : row_i[c];
    end else begin : g_low
      assign hi = shift_i ? row_i[c+1] : row_i[c];
    end

    assign row_o[c] = lo + hi;
  end

endmodule
